[rtl/core/wmf_pkg.sv]
package wmf_pkg;

  // Field and register widths
  localparam int PIX_W      = 32;
  localparam int COORD_W    = 10;
  localparam int WS_W       = 5;
  localparam int SIDE_W     = 11;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 11;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 56;

  // Parameter defaults
  localparam int DEF_MAX_WINDOW = 16;
  localparam int DEF_MAX_SIDE   = 1024;

  // Register reset values
  localparam logic [WS_W-1:0]   WS_RESET   = 5'd3;
  localparam logic [SIDE_W-1:0] SIDE_RESET = 11'd1024;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_SIDE  = 1'd1;

  // Control from the frame sequencer to the column stage
  typedef struct packed {
    logic rd_en;      // read the column word for an accepted pixel
    logic wr_en;      // write back the updated column word
    logic first_row;  // pixel in row 0: ignore the stored word
  } wmf_col_ctl_t;

  // Signed minimum of two samples
  function automatic logic signed [PIX_W-1:0] smin(input logic signed [PIX_W-1:0] a,
                                                   input logic signed [PIX_W-1:0] b);
    return (a < b) ? a : b;
  endfunction

endpackage

[rtl/core/wmf_row_cell.sv]
module wmf_row_cell
  import wmf_pkg::*;
(
  input  logic                    clk,
  input  logic                    en,
  input  logic                    restart,
  input  logic signed [PIX_W-1:0] px,
  input  logic signed [PIX_W-1:0] prev_min,
  output logic signed [PIX_W-1:0] min_q,
  output logic signed [PIX_W-1:0] min_nxt
);

  logic signed [PIX_W-1:0] min_r;

  // Cell i holds the minimum of the last i+1 samples of the row;
  // the first column of a row drops whatever came before.
  assign min_nxt = restart ? px : smin(prev_min, px);

  always_ff @(posedge clk) begin
    if (en) begin
      min_r <= min_nxt;
    end
  end

  assign min_q = min_r;

endmodule

[rtl/core/wmf_col_stage.sv]
module wmf_col_stage
  import wmf_pkg::*;
#(
  parameter int MAX_WINDOW = DEF_MAX_WINDOW,
  parameter int MAX_SIDE   = DEF_MAX_SIDE,
  localparam int AW = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1,
  localparam int IW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1
) (
  input  logic                    clk,
  input  wmf_col_ctl_t            ctl,
  input  logic [AW-1:0]           rd_addr,
  input  logic [AW-1:0]           wr_addr,
  input  logic [IW-1:0]           kidx,
  input  logic signed [PIX_W-1:0] rmin,
  output logic signed [PIX_W-1:0] win_min
);

  localparam int WORD_W = MAX_WINDOW * PIX_W;

  // One word per column: lane j holds the minimum of the row minimums
  // of the last j+1 rows at that column.
  logic [WORD_W-1:0] mem_r [MAX_SIDE];
  logic [WORD_W-1:0] rd_q_r;
  logic [WORD_W-1:0] wr_word;
  logic signed [PIX_W-1:0] lane_nxt [MAX_WINDOW];

  // Vertical cells: each lane takes its upper neighbor's stored value
  genvar j;
  generate
    for (j = 0; j < MAX_WINDOW; j++) begin : g_lane
      if (j == 0) begin : g_top
        assign lane_nxt[j] = rmin;
      end else begin : g_rest
        assign lane_nxt[j] = ctl.first_row ? rmin
                           : smin(rd_q_r[(j-1)*PIX_W +: PIX_W], rmin);
      end
      assign wr_word[j*PIX_W +: PIX_W] = lane_nxt[j];
    end
  endgenerate

  assign win_min = lane_nxt[kidx];

  // Column store: one read and one write port, registered read data
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem_r[wr_addr] <= wr_word;
    end
    if (ctl.rd_en) begin
      rd_q_r <= mem_r[rd_addr];
    end
  end

endmodule

[rtl/core/window_min_filter_2d.sv]
// Two-dimensional k by k minimum filter (grey-scale erosion) over a square frame of
// signed 32-bit pixels in raster order. Sustained rate is one pixel per clock; a pixel
// passes the column-store read stage and the output register, and the input stalls
// only while the output holds a result that has not been taken. A chain of MAX_WINDOW
// row cells keeps running row minimums; a column store of MAX_SIDE words, each
// MAX_WINDOW lanes wide, is read per pixel and written from column k-1 on.
// A result is given for each pixel whose row and column are both at least k-1, tagged
// with the window's top-left coordinates; tlast marks the frame's last result. If k
// exceeds the side, pixels are counted and no results are given. Any register write
// restarts the frame at row 0, column 0. The column store needs no clearing after reset.
module window_min_filter_2d
  import wmf_pkg::*;
#(
  parameter int MAX_WINDOW = DEF_MAX_WINDOW,
  parameter int MAX_SIDE   = DEF_MAX_SIDE
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // in_tdata: pixel_value[31:0]
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // out_tdata: window_min[31:0], out_row[41:32], out_col[51:42], zero pad[55:52]
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tlast,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int CW   = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam int IW   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int KW   = $clog2(MAX_WINDOW + 1);
  localparam int NW   = $clog2(MAX_SIDE + 1);
  localparam int CMPW = ((NW > KW) ? NW : KW) + 1;
  localparam int PADW = OUT_TDATA_W - PIX_W - 2 * COORD_W;

  // Configuration registers
  logic [WS_W-1:0]   ws_r;
  logic [SIDE_W-1:0] side_r;

  // Frame counters
  logic [CW-1:0] col_r, col_nxt;
  logic [CW-1:0] row_r, row_nxt;

  // Second stage (column store read in flight)
  logic                    vb_r;
  logic signed [PIX_W-1:0] rmin_b_r;
  logic [CW-1:0]           col_b_r;
  logic                    wr_b_r;
  logic                    prod_b_r;
  logic                    first_row_b_r;
  logic [COORD_W-1:0]      orow_b_r;
  logic [COORD_W-1:0]      ocol_b_r;
  logic                    flast_b_r;

  // Output register
  logic                    out_valid_r;
  logic signed [PIX_W-1:0] out_min_r;
  logic [COORD_W-1:0]      out_row_r;
  logic [COORD_W-1:0]      out_col_r;
  logic                    out_last_r;

  logic [KW-1:0]   k_eff;
  logic [NW-1:0]   n_eff;
  logic [IW-1:0]   kidx;
  logic [CMPW-1:0] k_cmp, n_cmp, col_p1, row_p1, row_diff, col_diff;
  logic [CMPW+COORD_W-1:0] row_ext, col_ext;
  logic win_ok, hit_col, hit_row, last_col, last_row, frame_end;
  logic acc, advance_b;

  logic signed [PIX_W-1:0] px;
  logic signed [PIX_W-1:0] rmin;
  logic signed [PIX_W-1:0] win_min;
  logic signed [PIX_W-1:0] cell_q   [MAX_WINDOW];
  logic signed [PIX_W-1:0] cell_nxt [MAX_WINDOW];
  wmf_col_ctl_t col_ctl;

  // Effective window and side, clamped to the supported range
  always_comb begin
    if (ws_r == '0) begin
      k_eff = KW'(1);
    end else if (32'(ws_r) > MAX_WINDOW) begin
      k_eff = KW'(MAX_WINDOW);
    end else begin
      k_eff = KW'(ws_r);
    end
    if (side_r == '0) begin
      n_eff = NW'(1);
    end else if (32'(side_r) > MAX_SIDE) begin
      n_eff = NW'(MAX_SIDE);
    end else begin
      n_eff = NW'(side_r);
    end
  end

  assign kidx   = IW'(k_eff - KW'(1));
  assign k_cmp  = CMPW'(k_eff);
  assign n_cmp  = CMPW'(n_eff);
  assign col_p1 = CMPW'(col_r) + CMPW'(1);
  assign row_p1 = CMPW'(row_r) + CMPW'(1);

  // Position decode for the pixel being accepted
  assign win_ok    = (k_cmp <= n_cmp);
  assign hit_col   = (col_p1 >= k_cmp);
  assign hit_row   = (row_p1 >= k_cmp);
  assign last_col  = (col_p1 >= n_cmp);
  assign last_row  = (row_p1 >= n_cmp);
  assign frame_end = (row_p1 == n_cmp) && (col_p1 == n_cmp);
  assign row_diff  = row_p1 - k_cmp;
  assign col_diff  = col_p1 - k_cmp;
  assign row_ext   = {{COORD_W{1'b0}}, row_diff};
  assign col_ext   = {{COORD_W{1'b0}}, col_diff};

  // Handshakes
  assign advance_b = vb_r && (!out_valid_r || out_tready);
  assign in_tready = rst_n && (!vb_r || advance_b);
  assign acc       = in_tvalid && in_tready;
  assign cfg_ready = rst_n;

  assign px = PIX_W'(in_tdata[PIX_W-1:0]);

  // Row cell chain
  genvar i;
  generate
    for (i = 0; i < MAX_WINDOW; i++) begin : g_cell
      logic signed [PIX_W-1:0] prev;
      if (i == 0) begin : g_head
        assign prev = px;
      end else begin : g_link
        assign prev = cell_q[i-1];
      end
      wmf_row_cell u_cell (
        .clk      (clk),
        .en       (acc),
        .restart  (col_r == '0),
        .px       (px),
        .prev_min (prev),
        .min_q    (cell_q[i]),
        .min_nxt  (cell_nxt[i])
      );
    end
  endgenerate

  assign rmin = cell_nxt[kidx];

  // Column stage
  assign col_ctl.rd_en     = acc;
  assign col_ctl.wr_en     = advance_b && wr_b_r;
  assign col_ctl.first_row = first_row_b_r;

  wmf_col_stage #(
    .MAX_WINDOW (MAX_WINDOW),
    .MAX_SIDE   (MAX_SIDE)
  ) u_col (
    .clk     (clk),
    .ctl     (col_ctl),
    .rd_addr (col_r),
    .wr_addr (col_b_r),
    .kidx    (kidx),
    .rmin    (rmin_b_r),
    .win_min (win_min)
  );

  // Next counter values
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (last_col) begin
      col_nxt = '0;
      row_nxt = last_row ? '0 : CW'(row_p1);
    end else begin
      col_nxt = CW'(col_p1);
    end
  end

  // Configuration and frame counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ws_r   <= WS_RESET;
      side_r <= SIDE_RESET;
      col_r  <= '0;
      row_r  <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_WINDOW_SIZE: begin
          ws_r  <= cfg_data[WS_W-1:0];
          col_r <= '0;
          row_r <= '0;
        end
        REG_IMAGE_SIDE: begin
          side_r <= cfg_data[SIDE_W-1:0];
          col_r  <= '0;
          row_r  <= '0;
        end
        default: begin
        end
      endcase
    end else if (acc) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // Second stage valid and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (acc) begin
        vb_r <= 1'b1;
      end else if (advance_b) begin
        vb_r <= 1'b0;
      end
      if (advance_b) begin
        out_valid_r <= prod_b_r;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Second stage and output payload
  always_ff @(posedge clk) begin
    if (acc) begin
      rmin_b_r      <= rmin;
      col_b_r       <= col_r;
      wr_b_r        <= win_ok && hit_col;
      prod_b_r      <= win_ok && hit_col && hit_row;
      first_row_b_r <= (row_r == '0);
      orow_b_r      <= row_ext[COORD_W-1:0];
      ocol_b_r      <= col_ext[COORD_W-1:0];
      flast_b_r     <= frame_end;
    end
    if (advance_b && prod_b_r) begin
      out_min_r  <= win_min;
      out_row_r  <= orow_b_r;
      out_col_r  <= ocol_b_r;
      out_last_r <= flast_b_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{PADW{1'b0}}, out_col_r, out_row_r, out_min_r};
  assign out_tlast  = out_last_r;

endmodule
